>>> rtl/alloc_stats_accumulator_top_assert.svh
// Assertion macros for the allocation statistics accumulator.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef ALLOC_STATS_ACCUMULATOR_TOP_ASSERT_SVH
`define ALLOC_STATS_ACCUMULATOR_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define ASA_CHK_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("asa assertion failed");

// Next-cycle implication, off while reset is asserted.
`define ASA_CHK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("asa assertion failed");

`endif

>>> rtl/asa_pkg.sv
// Shared types and constants of the allocation statistics accumulator.
// No dependencies.
package asa_pkg;

	localparam int DEF_CATEGORIES = 1024;
	localparam int BYTES_W        = 48;
	localparam int COUNT_W        = 32;
	localparam int AMOUNT_W       = 32;
	localparam int CAT_W          = 10;
	localparam int IN_DATA_W      = 48;
	localparam int OUT_DATA_W     = 424;

	localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_READ   = 1'b1;

	// Figures kept for one category or for the grand total.
	typedef struct packed {
		logic [BYTES_W-1:0] pk;
		logic [BYTES_W-1:0] ab;
		logic [BYTES_W-1:0] fb;
		logic [COUNT_W-1:0] ac;
		logic [COUNT_W-1:0] fc;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC1,
		ST_CALC2,
		ST_WB
	} state_t;

endpackage

>>> rtl/asa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module asa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/asa_rec.sv
// Two-step record datapath: saturating counter update, then live count and peak.
// Depends on asa_pkg.
module asa_rec (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic                                   alloc,
	input  logic [asa_pkg::AMOUNT_W-1:0]           mag,
	input  asa_pkg::entry_t                        cur,
	output asa_pkg::entry_t                        nxt_s2,
	output logic signed [asa_pkg::BYTES_W:0]       live_bytes_s2,
	output logic signed [asa_pkg::COUNT_W:0]       live_chunks_s2
);
	import asa_pkg::*;

	logic [BYTES_W:0]   sum_ab;
	logic [BYTES_W:0]   sum_fb;
	entry_t             upd;
	entry_t             ent_s1;
	entry_t             ent_pk;
	logic               en_s1;
	logic [BYTES_W:0]   live_b;
	logic [COUNT_W:0]   live_c;
	logic               raise;

	always_comb begin
		sum_ab = {1'b0, cur.ab} + (BYTES_W + 1)'(mag);
		sum_fb = {1'b0, cur.fb} + (BYTES_W + 1)'(mag);
		upd    = cur;
		if (en && alloc) begin
			upd.ab = sum_ab[BYTES_W] ? BYTES_MAX : sum_ab[BYTES_W-1:0];
			upd.ac = (cur.ac == COUNT_MAX) ? cur.ac : cur.ac + 1'b1;
		end else if (en) begin
			upd.fb = sum_fb[BYTES_W] ? BYTES_MAX : sum_fb[BYTES_W-1:0];
			upd.fc = (cur.fc == COUNT_MAX) ? cur.fc : cur.fc + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		ent_s1 <= upd;
		en_s1  <= en;
	end

	always_comb begin
		live_b = {1'b0, ent_s1.ab} - {1'b0, ent_s1.fb};
		live_c = {1'b0, ent_s1.ac} - {1'b0, ent_s1.fc};
		// raise only on a positive live count above the old peak
		raise  = en_s1 && !live_b[BYTES_W] && (live_b[BYTES_W-1:0] > ent_s1.pk);
		ent_pk = ent_s1;
		if (raise) begin
			ent_pk.pk = live_b[BYTES_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		nxt_s2         <= ent_pk;
		live_bytes_s2  <= live_b;
		live_chunks_s2 <= live_c;
	end

endmodule

>>> rtl/alloc_stats_accumulator_top.sv
// Allocation statistics accumulator: one item per record or read, one result item each.
// After acceptance an item passes the states CALC1, CALC2 and WB; result tvalid is registered on leaving WB.
// Items are accepted only in IDLE, so one read-modify-write of the category memory
// (read, update, peak, write back) is in flight at a time.
// Reset: arst_n clears control and totals, then a clearing pass writes zero to every
// category entry, one per cycle, with s_tready low.
module alloc_stats_accumulator_top #(
	parameter int CATEGORIES = asa_pkg::DEF_CATEGORIES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// category [9:0], amount [41:10], zero pad [47:42]
	input  logic [asa_pkg::IN_DATA_W-1:0]     s_tdata,
	// opcode [0]
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// cat_peak_bytes [47:0], cat_alloc_bytes [95:48], cat_live_bytes [144:96],
	// cat_alloc_chunks [176:145], cat_live_chunks [209:177], tot_peak_bytes [257:210],
	// tot_alloc_bytes [305:258], tot_live_bytes [354:306], tot_alloc_chunks [386:355],
	// tot_live_chunks [419:387], zero pad [423:420]
	output logic [asa_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import asa_pkg::*;

	localparam int AW = $clog2(CATEGORIES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(CATEGORIES - 1);

	state_t                   state_q;
	state_t                   state_nxt;
	logic [AW-1:0]            clr_q;
	logic                     accept;
	logic                     commit;
	logic                     clearing;
	logic                     out_free;

	logic [CAT_W-1:0]         cat_in;
	logic [AMOUNT_W-1:0]      amt_in;
	logic                     cat_ok;

	logic                     rec_q;
	logic                     cat_ok_q;
	logic                     alloc_q;
	logic [AMOUNT_W-1:0]      mag_q;
	logic [AW-1:0]            addr_q;

	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic [ENTRY_W-1:0]       ram_wdata;
	logic [ENTRY_W-1:0]       ram_rdata;

	entry_t                   cat_cur;
	entry_t                   cat_s2;
	entry_t                   tot_q;
	entry_t                   tot_s2;
	logic signed [BYTES_W:0]  cat_lb_s2;
	logic signed [COUNT_W:0]  cat_lc_s2;
	logic signed [BYTES_W:0]  tot_lb_s2;
	logic signed [COUNT_W:0]  tot_lc_s2;

	logic                     m_tvalid_q;
	logic [OUT_DATA_W-1:0]    m_tdata_q;

	assign cat_in   = s_tdata[CAT_W-1:0];
	assign amt_in   = s_tdata[CAT_W +: AMOUNT_W];
	assign cat_ok   = 32'(cat_in) < 32'(CATEGORIES);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		clearing  = 1'b0;
		commit    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				clearing = 1'b1;
				if (clr_q == LAST_ADDR) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_nxt = ST_CALC1;
				end
			end
			ST_CALC1: state_nxt = ST_CALC2;
			ST_CALC2: state_nxt = ST_WB;
			ST_WB: begin
				// hold until the output register can take the result
				if (out_free) begin
					commit    = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rec_q    <= (s_tuser == OP_RECORD);
			cat_ok_q <= cat_ok;
			addr_q   <= AW'(cat_in);
			alloc_q  <= !amt_in[AMOUNT_W-1] && (amt_in != '0);
			mag_q    <= amt_in[AMOUNT_W-1] ? (~amt_in + 1'b1) : amt_in;
		end
	end

	assign ram_we    = clearing || (commit && rec_q && cat_ok_q);
	assign ram_waddr = clearing ? clr_q : addr_q;
	assign ram_wdata = clearing ? '0 : ENTRY_W'(cat_s2);

	asa_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CATEGORIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (AW'(cat_in)),
		.rdata (ram_rdata)
	);

	// out-of-range category reads as all zero and is never written
	assign cat_cur = cat_ok_q ? entry_t'(ram_rdata) : '0;

	asa_rec u_cat_rec (
		.clk            (clk),
		.en             (rec_q && cat_ok_q),
		.alloc          (alloc_q),
		.mag            (mag_q),
		.cur            (cat_cur),
		.nxt_s2         (cat_s2),
		.live_bytes_s2  (cat_lb_s2),
		.live_chunks_s2 (cat_lc_s2)
	);

	asa_rec u_tot_rec (
		.clk            (clk),
		.en             (rec_q),
		.alloc          (alloc_q),
		.mag            (mag_q),
		.cur            (tot_q),
		.nxt_s2         (tot_s2),
		.live_bytes_s2  (tot_lb_s2),
		.live_chunks_s2 (tot_lc_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q <= '0;
		end else if (commit && rec_q) begin
			tot_q <= tot_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (commit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			m_tdata_q <= {4'b0,
				tot_lc_s2, tot_s2.ac, tot_lb_s2, tot_s2.ab, tot_s2.pk,
				cat_lc_s2, cat_s2.ac, cat_lb_s2, cat_s2.ab, cat_s2.pk};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> rtl/asa_port_check.sv
// Port-level checker for the allocation statistics accumulator, bound to the top level.
// Depends on asa_pkg and alloc_stats_accumulator_top_assert.svh.
`include "alloc_stats_accumulator_top_assert.svh"

module asa_port_check (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [asa_pkg::OUT_DATA_W-1:0] m_tdata
);
	import asa_pkg::*;

	// a stalled result item stays put
	`ASA_CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// one item in flight: no accept right after an accept
	`ASA_CHK_NEXT(a_one_busy, s_tvalid && s_tready, !s_tready)

	// total peak is never below a positive live byte count
	`ASA_CHK_NOW(a_tot_peak, m_tvalid && !m_tdata[354],
		m_tdata[353:306] <= m_tdata[257:210])

	// no allocation events means no allocated bytes
	`ASA_CHK_NOW(a_tot_alloc, m_tvalid && (m_tdata[386:355] == '0),
		m_tdata[305:258] == '0)

endmodule

bind alloc_stats_accumulator_top asa_port_check u_asa_port_check (.*);

>>> tb/tb_alloc_stats_accumulator_top.sv
// Self-checking testbench for alloc_stats_accumulator_top: directed table, then random
// event traces with sender gaps and receiver stalls.
// Depends on asa_pkg and the accumulator RTL only.
module tb_alloc_stats_accumulator_top;
	import asa_pkg::*;

	localparam int DIR_ROWS  = 20;
	localparam int RAND_ITEMS = 1300;

	// Figures of one side of a result item, last field in the lowest bits.
	typedef struct packed {
		logic [COUNT_W:0]   live_chunks;
		logic [COUNT_W-1:0] alloc_chunks;
		logic [BYTES_W:0]   live_bytes;
		logic [BYTES_W-1:0] alloc_bytes;
		logic [BYTES_W-1:0] peak_bytes;
	} fig_view_t;

	typedef struct packed {
		logic [3:0] pad;
		fig_view_t  tot;
		fig_view_t  cat;
	} stats_res_t;

	typedef struct packed {
		logic                op;
		logic [CAT_W-1:0]    cat;
		logic [AMOUNT_W-1:0] amt;
		logic                typed;
		stats_res_t          want;
	} dir_row_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_RANDOM,
		RX_PERIODIC
	} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	entry_t     cat_fig [DEF_CATEGORIES];
	entry_t     tot_fig;
	stats_res_t expected_figures [$];
	dir_row_t   dir_rows [DIR_ROWS];
	int         mismatch_count = 0;

	alloc_stats_accumulator_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [BYTES_W-1:0] sat_add48(logic [BYTES_W-1:0] a,
			logic [AMOUNT_W-1:0] b);
		logic [BYTES_W:0] s;
		s = {1'b0, a} + {{(BYTES_W-AMOUNT_W+1){1'b0}}, b};
		return s[BYTES_W] ? BYTES_MAX : s[BYTES_W-1:0];
	endfunction

	// Apply one event to a set of figures and raise its peak.
	function automatic entry_t bump_figures(entry_t f, logic is_alloc,
			logic [AMOUNT_W-1:0] mag);
		logic signed [BYTES_W:0] live;
		if (is_alloc) begin
			f.ab = sat_add48(f.ab, mag);
			f.ac = (f.ac == COUNT_MAX) ? f.ac : f.ac + 1'b1;
		end else begin
			f.fb = sat_add48(f.fb, mag);
			f.fc = (f.fc == COUNT_MAX) ? f.fc : f.fc + 1'b1;
		end
		live = $signed({1'b0, f.ab}) - $signed({1'b0, f.fb});
		if (live > 0 && live[BYTES_W-1:0] > f.pk)
			f.pk = live[BYTES_W-1:0];
		return f;
	endfunction

	function automatic fig_view_t view_of(entry_t f);
		fig_view_t v;
		v.peak_bytes   = f.pk;
		v.alloc_bytes  = f.ab;
		v.live_bytes   = {1'b0, f.ab} - {1'b0, f.fb};
		v.alloc_chunks = f.ac;
		v.live_chunks  = {1'b0, f.ac} - {1'b0, f.fc};
		return v;
	endfunction

	function automatic stats_res_t predict_stats(logic op, logic [CAT_W-1:0] cat,
			logic [AMOUNT_W-1:0] amt);
		logic                is_alloc;
		logic [AMOUNT_W-1:0] mag;
		stats_res_t          r;
		is_alloc = !amt[AMOUNT_W-1] && (amt != '0);
		// most negative amount frees 2^31, which still fits in 32 bits
		mag = amt[AMOUNT_W-1] ? -amt : amt;
		if (op == OP_RECORD) begin
			cat_fig[cat] = bump_figures(cat_fig[cat], is_alloc, mag);
			tot_fig      = bump_figures(tot_fig, is_alloc, mag);
		end
		r     = '0;
		r.cat = view_of(cat_fig[cat]);
		r.tot = view_of(tot_fig);
		return r;
	endfunction

	// Present one item from the falling edge on and hold it until accepted.
	task automatic send_item(input logic op, input logic [CAT_W-1:0] cat,
			input logic [AMOUNT_W-1:0] amt, input logic typed, input stats_res_t want);
		stats_res_t predicted;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(IN_DATA_W-AMOUNT_W-CAT_W){1'b0}}, amt, cat};
		do
			@(posedge clk);
		while (!s_tready);
		predicted = predict_stats(op, cat, amt);
		expected_figures.push_back(typed ? want : predicted);
	endtask

	task automatic hold_off(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
	endtask

	task automatic drain_results();
		while (expected_figures.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_view(input string side, input fig_view_t e, input fig_view_t a);
		if (e.peak_bytes !== a.peak_bytes) begin
			mismatch_count++;
			$display("%0t %s_peak_bytes expected %h actual %h", $time, side,
				e.peak_bytes, a.peak_bytes);
		end
		if (e.alloc_bytes !== a.alloc_bytes) begin
			mismatch_count++;
			$display("%0t %s_alloc_bytes expected %h actual %h", $time, side,
				e.alloc_bytes, a.alloc_bytes);
		end
		if (e.live_bytes !== a.live_bytes) begin
			mismatch_count++;
			$display("%0t %s_live_bytes expected %h actual %h", $time, side,
				e.live_bytes, a.live_bytes);
		end
		if (e.alloc_chunks !== a.alloc_chunks) begin
			mismatch_count++;
			$display("%0t %s_alloc_chunks expected %h actual %h", $time, side,
				e.alloc_chunks, a.alloc_chunks);
		end
		if (e.live_chunks !== a.live_chunks) begin
			mismatch_count++;
			$display("%0t %s_live_chunks expected %h actual %h", $time, side,
				e.live_chunks, a.live_chunks);
		end
	endtask

	always @(posedge clk) begin
		stats_res_t got;
		stats_res_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			got = stats_res_t'(m_tdata);
			if (expected_figures.size() == 0) begin
				mismatch_count++;
				$display("%0t unexpected result item: expected none actual %h", $time,
					m_tdata);
			end else begin
				exp_res = expected_figures.pop_front();
				check_view("cat", exp_res.cat, got.cat);
				check_view("tot", exp_res.tot, got.tot);
				if (got.pad !== 4'd0) begin
					mismatch_count++;
					$display("%0t pad expected 0 actual %h", $time, got.pad);
				end
			end
		end
	end

	// Receiver: choose a new stall pattern each time rx_tick wraps to zero.
	initial begin
		rx_mode_t rx_mode;
		logic [5:0] rx_tick;
		rx_mode  = RX_OPEN;
		rx_tick  = '0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_tick == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_tick = rx_tick + 1'b1;
			case (rx_mode)
				RX_OPEN:     m_tready <= 1'b1;
				RX_RANDOM:   m_tready <= ($urandom_range(0, 2) != 0);
				default:     m_tready <= (rx_tick % 7) > 2;
			endcase
		end
	end

	initial begin
		fig_view_t           first_alloc;
		stats_res_t          first_res;
		logic                op;
		logic [CAT_W-1:0]    cat;
		logic [AMOUNT_W-1:0] amt;
		int                  burst_left;

		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = OP_RECORD;
		s_tdata  = '0;
		for (int i = 0; i < DEF_CATEGORIES; i++)
			cat_fig[i] = '0;
		tot_fig = '0;

		first_alloc = '{live_chunks: 33'd1, alloc_chunks: 32'd1,
			live_bytes: 49'h7FFF_FFFF, alloc_bytes: 48'h7FFF_FFFF,
			peak_bytes: 48'h7FFF_FFFF};
		first_res = '{pad: 4'd0, tot: first_alloc, cat: first_alloc};

		dir_rows[0]  = '{OP_READ,   10'd0,    32'h0000_0000, 1'b1, '0};
		dir_rows[1]  = '{OP_READ,   10'd1023, 32'hFFFF_FFFF, 1'b1, '0};
		dir_rows[2]  = '{OP_RECORD, 10'd1023, 32'h7FFF_FFFF, 1'b1, first_res};
		dir_rows[3]  = '{OP_RECORD, 10'd2,    32'h8000_0000, 1'b0, '0};
		dir_rows[4]  = '{OP_RECORD, 10'd2,    32'h0000_0000, 1'b0, '0};
		dir_rows[5]  = '{OP_RECORD, 10'd2,    32'h0000_0001, 1'b0, '0};
		dir_rows[6]  = '{OP_RECORD, 10'd2,    32'hFFFF_FFFF, 1'b0, '0};
		dir_rows[7]  = '{OP_READ,   10'd2,    32'h5555_5555, 1'b0, '0};
		dir_rows[8]  = '{OP_RECORD, 10'd1023, 32'h8000_0000, 1'b0, '0};
		dir_rows[9]  = '{OP_RECORD, 10'd1023, 32'h7FFF_FFFF, 1'b0, '0};
		dir_rows[10] = '{OP_RECORD, 10'd1023, 32'h7FFF_FFFF, 1'b0, '0};
		dir_rows[11] = '{OP_READ,   10'd1023, 32'h0000_0000, 1'b0, '0};
		dir_rows[12] = '{OP_RECORD, 10'd512,  32'h5555_5555, 1'b0, '0};
		dir_rows[13] = '{OP_RECORD, 10'd341,  32'hAAAA_AAAA, 1'b0, '0};
		dir_rows[14] = '{OP_RECORD, 10'd341,  32'h0000_0100, 1'b0, '0};
		dir_rows[15] = '{OP_READ,   10'd341,  32'h0000_0000, 1'b0, '0};
		dir_rows[16] = '{OP_RECORD, 10'd1,    32'h0000_0001, 1'b0, '0};
		dir_rows[17] = '{OP_RECORD, 10'd0,    32'h7FFF_FFFF, 1'b0, '0};
		dir_rows[18] = '{OP_READ,   10'd1022, 32'h0000_0000, 1'b0, '0};
		dir_rows[19] = '{OP_READ,   10'd0,    32'h8000_0000, 1'b0, '0};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// back-to-back so repeated categories follow each other through read-modify-write
		for (int i = 0; i < DIR_ROWS; i++)
			send_item(dir_rows[i].op, dir_rows[i].cat, dir_rows[i].amt,
				dir_rows[i].typed, dir_rows[i].want);

		// pause until every result is back
		hold_off(1);
		drain_results();

		burst_left = 0;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (burst_left == 0) begin
				hold_off($urandom_range(0, 9) < 3 ? 0 : $urandom_range(1, 8));
				burst_left = $urandom_range(1, 20);
			end
			burst_left--;
			op = ($urandom_range(0, 3) == 0) ? OP_READ : OP_RECORD;
			// mostly a few hot categories to stress read-modify-write ordering
			cat = ($urandom_range(0, 9) < 6) ? CAT_W'($urandom_range(0, 7))
				: CAT_W'($urandom_range(0, DEF_CATEGORIES - 1));
			case ($urandom_range(0, 8))
				0:       amt = '0;
				1, 2:    amt = $urandom_range(1, 4096);
				3:       amt = -$urandom_range(1, 4096);
				4:       amt = 32'h7FFF_FFFF;
				5:       amt = 32'h8000_0000;
				default: amt = $urandom;
			endcase
			send_item(op, cat, amt, 1'b0, '0);
		end

		hold_off(1);
		drain_results();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && expected_figures.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> alloc_stats_accumulator_top.f
+incdir+rtl
rtl/asa_pkg.sv
rtl/asa_ram.sv
rtl/asa_rec.sv
rtl/alloc_stats_accumulator_top.sv
rtl/asa_port_check.sv
tb/tb_alloc_stats_accumulator_top.sv
